[rtl/kdre_pkg.sv]
`default_nettype none

package kdre_pkg;

  // Default configuration.
  localparam int NUM_KEYS_DEF      = 16;
  localparam int DEBOUNCE_BITS_DEF = 4;

  // Widths of the fixed item fields and of the per-key counters.
  localparam int KEY_W  = 4;
  localparam int CNT_W  = 8;
  localparam int DBL_W  = 2;
  localparam int MODE_W = 4;

  // Tick thresholds of the key mode machine.
  localparam logic [CNT_W-1:0] TICK_LONG         = 8'd24;
  localparam logic [CNT_W-1:0] TICK_REPEAT_START = 8'd40;
  localparam logic [CNT_W-1:0] TICK_SPEEDUP      = 8'd48;
  localparam logic [CNT_W-1:0] TICK_PAUSE_END    = 8'd64;
  localparam logic [CNT_W-1:0] TICK_DOUBLE       = 8'd16;

  // Item operations.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PAUSE = 2'd1,
    OP_KILL  = 2'd2
  } op_e;

  // Event codes carried by a result item.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_FIRST   = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_e;

  // Per-key mode; the repeat modes run from the slowest to the fastest period.
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF    = 4'd0,
    MODE_START  = 4'd1,
    MODE_DELAY  = 4'd2,
    MODE_PAUSE  = 4'd3,
    MODE_KILLED = 4'd4,
    MODE_RPT16  = 4'd5,
    MODE_RPT8   = 4'd6,
    MODE_RPT4   = 4'd7,
    MODE_RPT2   = 4'd8,
    MODE_RPT1   = 4'd9
  } mode_e;

  // Per-key state besides the debounce history.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [DBL_W-1:0] dbl;
    mode_e            mode;
  } key_state_t;

endpackage

`default_nettype wire

[rtl/kdre_ram.sv]
`default_nettype none

module kdre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/kdre_update.sv]
`default_nettype none

module kdre_update #(
  parameter int DEBOUNCE_BITS = kdre_pkg::DEBOUNCE_BITS_DEF
) (
  input  wire logic [1:0]               op_i,
  input  wire logic                     raw_sample_i,
  input  wire logic [DEBOUNCE_BITS-1:0] hist_i,
  input  wire kdre_pkg::key_state_t     state_i,
  output logic      [DEBOUNCE_BITS-1:0] hist_o,
  output kdre_pkg::key_state_t          state_o,
  output kdre_pkg::event_e              event_o
);

  logic [DEBOUNCE_BITS-1:0]     hist;
  logic [kdre_pkg::CNT_W-1:0]   cnt;
  logic [kdre_pkg::DBL_W-1:0]   dbl;
  kdre_pkg::mode_e              mode;
  kdre_pkg::event_e             ev;
  logic [3:0]                   period_mask;

  always_comb begin
    hist        = DEBOUNCE_BITS'({hist_i, raw_sample_i});
    cnt         = state_i.cnt + kdre_pkg::CNT_W'(1);
    dbl         = state_i.dbl;
    mode        = state_i.mode;
    ev          = kdre_pkg::EV_NONE;
    period_mask = '0;

    hist_o  = hist_i;
    state_o = state_i;
    event_o = kdre_pkg::EV_NONE;

    case (kdre_pkg::op_e'(op_i))
      kdre_pkg::OP_TICK: begin
        // A fully released key leaves any active mode.
        if ((mode != kdre_pkg::MODE_OFF) && (hist == '0)) begin
          if (mode != kdre_pkg::MODE_KILLED) begin
            ev = kdre_pkg::EV_RELEASE;
            if (!((mode == kdre_pkg::MODE_RPT16) && (cnt < kdre_pkg::TICK_DOUBLE))) begin
              dbl = '0;
            end
          end
          cnt  = '0;
          mode = kdre_pkg::MODE_OFF;
        end

        // Mode machine.
        case (mode)
          kdre_pkg::MODE_OFF: begin
            if (hist == '1) begin
              mode = kdre_pkg::MODE_START;
              // A slow second press restarts the double-press count.
              if (cnt > kdre_pkg::TICK_DOUBLE) begin
                dbl = '0;
              end
              cnt = '0;
            end
          end
          kdre_pkg::MODE_START: begin
            ev   = kdre_pkg::EV_FIRST;
            dbl  = dbl + kdre_pkg::DBL_W'(1);
            mode = kdre_pkg::MODE_DELAY;
            cnt  = '0;
          end
          kdre_pkg::MODE_DELAY: begin
            if (cnt == kdre_pkg::TICK_LONG) begin
              ev = kdre_pkg::EV_LONG;
            end
            if (cnt == kdre_pkg::TICK_REPEAT_START) begin
              mode = kdre_pkg::MODE_RPT16;
              cnt  = '0;
            end
          end
          kdre_pkg::MODE_RPT16, kdre_pkg::MODE_RPT8, kdre_pkg::MODE_RPT4,
          kdre_pkg::MODE_RPT2, kdre_pkg::MODE_RPT1: begin
            // Speed up after each stretch until the fastest period.
            if ((mode != kdre_pkg::MODE_RPT1) && (cnt >= kdre_pkg::TICK_SPEEDUP)) begin
              mode = kdre_pkg::mode_e'(kdre_pkg::MODE_W'(mode) + kdre_pkg::MODE_W'(1));
              cnt  = '0;
            end
            case (mode)
              kdre_pkg::MODE_RPT16: period_mask = 4'hf;
              kdre_pkg::MODE_RPT8:  period_mask = 4'h7;
              kdre_pkg::MODE_RPT4:  period_mask = 4'h3;
              kdre_pkg::MODE_RPT2:  period_mask = 4'h1;
              default:              period_mask = 4'h0;
            endcase
            if ((cnt[3:0] & period_mask) == 4'h0) begin
              ev = kdre_pkg::EV_REPEAT;
            end
          end
          kdre_pkg::MODE_PAUSE: begin
            if (cnt >= kdre_pkg::TICK_PAUSE_END) begin
              mode = kdre_pkg::MODE_RPT8;
              cnt  = '0;
            end
          end
          default: begin
          end
        endcase

        hist_o        = hist;
        state_o.cnt   = cnt;
        state_o.dbl   = dbl;
        state_o.mode  = mode;
        event_o       = ev;
      end
      kdre_pkg::OP_PAUSE: begin
        state_o.mode = kdre_pkg::MODE_PAUSE;
        state_o.cnt  = '0;
      end
      kdre_pkg::OP_KILL: begin
        state_o.mode = kdre_pkg::MODE_KILLED;
        state_o.dbl  = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/key_debounce_repeat_events.sv]
// Key qualifier with debounce, long press, auto-repeat and double-press count.
// Input channel: in_valid_i / in_stall_o carry one item per key sample or
// command (operation_i, key_index_i, raw_sample_i). Output channel:
// out_valid_o / out_stall_i return exactly one result item per input item,
// in order (event_kind_o, event_key_o, key_down_o, press_count_o).
// A result item passes from the read stage register into the output register,
// where it is offered until the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall. Per-key
// state lives in a single RAM with a registered read; the read-modify-write
// of a key closes when its item leaves the read stage, and a key addressed by
// two items in a row takes its state from a bypass register holding the last write.
// Reset clears all control state and marks every key entry as unwritten,
// so each key reads as released with zero counters; no clearing pass runs.
// When the receiver stalls, the result waits in the output register, one
// more item waits in the read stage, and then in_stall_o rises until the
// output register drains.
`default_nettype none

module key_debounce_repeat_events #(
  parameter int NUM_KEYS_P    = kdre_pkg::NUM_KEYS_DEF,
  parameter int DEBOUNCE_BITS = kdre_pkg::DEBOUNCE_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                operation_i,
  input  wire logic [kdre_pkg::KEY_W-1:0] key_index_i,
  input  wire logic                      raw_sample_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [2:0]                event_kind_o,
  output logic      [kdre_pkg::KEY_W-1:0] event_key_o,
  output logic                           key_down_o,
  output logic      [kdre_pkg::DBL_W-1:0] press_count_o
);

  localparam int AW   = (NUM_KEYS_P > 1) ? $clog2(NUM_KEYS_P) : 1;
  localparam int KW   = (AW > kdre_pkg::KEY_W) ? AW : kdre_pkg::KEY_W;
  localparam int KS_W = $bits(kdre_pkg::key_state_t);
  localparam int EW   = DEBOUNCE_BITS + KS_W;

  // Handshake and pipeline control.
  logic in_accept;
  logic s1_advance;
  logic out_valid_q;

  // Read stage.
  logic                       s1_valid_q;
  logic [1:0]                 s1_op_q;
  logic [kdre_pkg::KEY_W-1:0] s1_key_q;
  logic                       s1_level_q;
  logic                       s1_in_range_q;
  logic [AW-1:0]              s1_addr_q;

  // Address and range of the incoming item.
  logic [KW-1:0] key_ext;
  logic [AW-1:0] in_addr;
  logic          in_range;

  // State storage, unwritten marks and write bypass.
  logic [NUM_KEYS_P-1:0] written_q;
  logic                  lw_valid_q;
  logic [AW-1:0]         lw_addr_q;
  logic [EW-1:0]         lw_data_q;
  logic [EW-1:0]         rd_data;
  logic [EW-1:0]         cur_entry;
  logic                  wr_en;
  logic [EW-1:0]         wr_data;

  // Update results.
  logic [DEBOUNCE_BITS-1:0] new_hist;
  kdre_pkg::key_state_t     new_state;
  kdre_pkg::event_e         new_event;

  // Output register.
  kdre_pkg::event_e           event_q;
  logic [kdre_pkg::KEY_W-1:0] key_q;
  logic                       down_q;
  logic [kdre_pkg::DBL_W-1:0] pc_q;

  assign s1_advance = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign key_ext  = KW'(key_index_i);
  assign in_addr  = key_ext[AW-1:0];
  assign in_range = (32'(key_index_i) < 32'(NUM_KEYS_P));

  // Read stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q       <= operation_i;
      s1_key_q      <= key_index_i;
      s1_level_q    <= raw_sample_i;
      s1_in_range_q <= in_range;
      s1_addr_q     <= in_addr;
    end
  end

  kdre_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_KEYS_P)
  ) u_state_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_data)
  );

  // Current entry: the last write wins, then the RAM, then the reset value.
  always_comb begin
    if (lw_valid_q && (lw_addr_q == s1_addr_q)) begin
      cur_entry = lw_data_q;
    end else if (written_q[s1_addr_q]) begin
      cur_entry = rd_data;
    end else begin
      cur_entry = '0;
    end
  end

  kdre_update #(
    .DEBOUNCE_BITS (DEBOUNCE_BITS)
  ) u_update (
    .op_i         (s1_op_q),
    .raw_sample_i (s1_level_q),
    .hist_i       (cur_entry[EW-1 -: DEBOUNCE_BITS]),
    .state_i      (kdre_pkg::key_state_t'(cur_entry[KS_W-1:0])),
    .hist_o       (new_hist),
    .state_o      (new_state),
    .event_o      (new_event)
  );

  assign wr_en   = s1_advance && s1_in_range_q;
  assign wr_data = {new_hist, new_state};

  // Unwritten marks and bypass of the most recent write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      lw_valid_q <= 1'b0;
    end else if (wr_en) begin
      written_q[s1_addr_q] <= 1'b1;
      lw_valid_q           <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= wr_data;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      key_q <= s1_key_q;
      if (s1_in_range_q) begin
        event_q <= new_event;
        down_q  <= (new_hist == '1);
        pc_q    <= new_state.dbl;
      end else begin
        event_q <= kdre_pkg::EV_NONE;
        down_q  <= 1'b0;
        pc_q    <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = event_q;
  assign event_key_o   = key_q;
  assign key_down_o    = down_q;
  assign press_count_o = pc_q;

  // The state RAM is written only when the item moves on to the output.
  a_write_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s1_advance)
    else $error("state written without the item advancing");

  // An item leaving the read stage shows up at the output.
  a_advance_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> out_valid_q)
    else $error("advanced item missing from output register");

  // Input stalls only when both stages are full and the output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // Written modes stay within the defined codes.
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (new_state.mode <= kdre_pkg::MODE_RPT1))
    else $error("undefined key mode written");

  // A release event always reports the key as up.
  a_release_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (event_q == kdre_pkg::EV_RELEASE)) |-> !down_q)
    else $error("release reported with key down");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int KEY_COUNT     = kdre_pkg::NUM_KEYS_DEF;
  localparam int DB_BITS       = kdre_pkg::DEBOUNCE_BITS_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 10;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [kdre_pkg::CNT_W-1:0] PERIOD_SLOWEST = 8'd16;

  // Expected content of one result item.
  typedef struct packed {
    kdre_pkg::event_e           kind;
    logic [kdre_pkg::KEY_W-1:0] key;
    logic                       down;
    logic [kdre_pkg::DBL_W-1:0] presses;
  } key_report_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 operation_i;
  logic [kdre_pkg::KEY_W-1:0] key_index_i;
  logic                       raw_sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [2:0]                 event_kind_o;
  logic [kdre_pkg::KEY_W-1:0] event_key_o;
  logic                       key_down_o;
  logic [kdre_pkg::DBL_W-1:0] press_count_o;

  // Shadow copy of the per-key state.
  logic [DB_BITS-1:0]         hist_q     [KEY_COUNT];
  logic [kdre_pkg::CNT_W-1:0] ticks_q    [KEY_COUNT];
  logic [kdre_pkg::DBL_W-1:0] presses_q  [KEY_COUNT];
  kdre_pkg::mode_e            mode_q     [KEY_COUNT];

  key_report_t expected_reports[$];
  int          errors;
  int          cycles;
  int          send_gap_max;
  int          recv_gap_max;

  // Planned levels for the multi-key scan.
  logic        plan_level [KEY_COUNT];
  int          plan_left  [KEY_COUNT];

  key_debounce_repeat_events DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .key_index_i   (key_index_i),
    .raw_sample_i  (raw_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_key_o   (event_key_o),
    .key_down_o    (key_down_o),
    .press_count_o (press_count_o)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One sample tick of one key's mode machine; updates the shadow state.
  function automatic kdre_pkg::event_e tick_key(int k, logic level);
    logic [DB_BITS-1:0]         hist;
    logic [kdre_pkg::CNT_W-1:0] cnt;
    logic [kdre_pkg::CNT_W-1:0] period_mask;
    logic [kdre_pkg::DBL_W-1:0] dbl;
    kdre_pkg::mode_e            mode;
    kdre_pkg::event_e           ev;
    int                         shift;
    hist = (hist_q[k] << 1) | DB_BITS'(level);
    cnt  = ticks_q[k] + 8'd1;
    mode = mode_q[k];
    dbl  = presses_q[k];
    ev   = kdre_pkg::EV_NONE;

    // A fully released history ends any active mode.
    if (mode != kdre_pkg::MODE_OFF && hist == '0) begin
      if (mode != kdre_pkg::MODE_KILLED) begin
        ev = kdre_pkg::EV_RELEASE;
        if (!(mode == kdre_pkg::MODE_RPT16 && cnt < kdre_pkg::TICK_DOUBLE)) begin
          dbl = '0;
        end
      end
      cnt  = '0;
      mode = kdre_pkg::MODE_OFF;
    end

    case (mode)
      kdre_pkg::MODE_OFF: begin
        if (hist == '1) begin
          mode = kdre_pkg::MODE_START;
          if (cnt > kdre_pkg::TICK_DOUBLE) begin
            dbl = '0;
          end
          cnt = '0;
        end
      end
      kdre_pkg::MODE_START: begin
        ev   = kdre_pkg::EV_FIRST;
        dbl  = dbl + 2'd1;
        mode = kdre_pkg::MODE_DELAY;
        cnt  = '0;
      end
      kdre_pkg::MODE_DELAY: begin
        if (cnt == kdre_pkg::TICK_LONG) begin
          ev = kdre_pkg::EV_LONG;
        end
        if (cnt == kdre_pkg::TICK_REPEAT_START) begin
          mode = kdre_pkg::MODE_RPT16;
          cnt  = '0;
        end
      end
      kdre_pkg::MODE_PAUSE: begin
        if (cnt >= kdre_pkg::TICK_PAUSE_END) begin
          mode = kdre_pkg::MODE_RPT8;
          cnt  = '0;
        end
      end
      kdre_pkg::MODE_KILLED: begin
      end
      default: begin
        // Repeating: speed up every speedup interval, then test the period.
        if (mode != kdre_pkg::MODE_RPT1 && cnt >= kdre_pkg::TICK_SPEEDUP) begin
          mode = kdre_pkg::mode_e'(mode + 4'd1);
          cnt  = '0;
        end
        shift       = int'(mode) - int'(kdre_pkg::MODE_RPT16);
        period_mask = (PERIOD_SLOWEST >> shift) - 8'd1;
        if ((cnt & period_mask) == '0) begin
          ev = kdre_pkg::EV_REPEAT;
        end
      end
    endcase

    hist_q[k]    = hist;
    ticks_q[k]   = cnt;
    mode_q[k]    = mode;
    presses_q[k] = dbl;
    return ev;
  endfunction

  // Works out the result of one accepted item and queues it.
  function automatic void predict_report(logic [1:0] op, logic [kdre_pkg::KEY_W-1:0] key,
                                         logic level);
    key_report_t r;
    r.kind    = kdre_pkg::EV_NONE;
    r.key     = key;
    r.down    = 1'b0;
    r.presses = '0;
    if (int'(key) < KEY_COUNT) begin
      case (op)
        kdre_pkg::OP_TICK: r.kind = tick_key(key, level);
        kdre_pkg::OP_PAUSE: begin
          mode_q[key]  = kdre_pkg::MODE_PAUSE;
          ticks_q[key] = '0;
        end
        kdre_pkg::OP_KILL: begin
          mode_q[key]    = kdre_pkg::MODE_KILLED;
          presses_q[key] = '0;
        end
        default: begin
        end
      endcase
      r.down    = (hist_q[key] == '1);
      r.presses = presses_q[key];
    end
    expected_reports.push_back(r);
  endfunction

  function automatic int draw_gap(int max_gap);
    return (max_gap == 0) ? 0 : int'($urandom_range(0, max_gap));
  endfunction

  // Sends one item; called and returns at a falling edge.
  task automatic send_item(logic [1:0] op, logic [kdre_pkg::KEY_W-1:0] key, logic level);
    int gap;
    gap = draw_gap(send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i  <= op;
    key_index_i  <= key;
    raw_sample_i <= level;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_report(op, key, level);
    @(negedge clk_i);
  endtask

  task automatic hold_key(logic [kdre_pkg::KEY_W-1:0] key, logic level, int n);
    repeat (n) send_item(kdre_pkg::OP_TICK, key, level);
  endtask

  // Holds off the sender until every queued result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: a random stall before each result item.
  initial begin
    int gap;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = draw_gap(recv_gap_max);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compares each accepted result item with the oldest expectation.
  always @(posedge clk_i) begin
    key_report_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result item for key %0d with nothing expected", $time, event_key_o);
        errors++;
      end else begin
        exp_r = expected_reports.pop_front();
        check_field("event_kind", int'(exp_r.kind), int'(event_kind_o));
        check_field("event_key", int'(exp_r.key), int'(event_key_o));
        check_field("key_down", int'(exp_r.down), int'(key_down_o));
        check_field("press_count", int'(exp_r.presses), int'(press_count_o));
      end
    end
  end

  // Released keys, extremes of the key index.
  task automatic test_idle_ticks();
    send_item(kdre_pkg::OP_TICK, 4'd0, 1'b0);
    send_item(kdre_pkg::OP_TICK, 4'd15, 1'b0);
    send_item(kdre_pkg::OP_TICK, 4'd15, 1'b1);
  endtask

  // One clean press: debounce, first press, then release.
  task automatic test_press_release();
    hold_key(4'd3, 1'b1, 5);
    hold_key(4'd3, 1'b0, 4);
  endtask

  // Pause from rest gives a release, kill from rest is silent, code 3 is ignored.
  task automatic test_commands();
    send_item(kdre_pkg::OP_PAUSE, 4'd5, 1'b1);
    send_item(kdre_pkg::OP_TICK, 4'd5, 1'b0);
    send_item(kdre_pkg::OP_KILL, 4'd6, 1'b1);
    send_item(kdre_pkg::OP_TICK, 4'd6, 1'b0);
    send_item(OP_RESERVED, 4'd7, 1'b1);
  endtask

  // Long holds through every repeat speed, double press, pause and kill.
  task automatic test_long_hold();
    hold_key(4'd9, 1'b1, 260);
    hold_key(4'd9, 1'b0, 6);
    hold_key(4'd9, 1'b1, 10);
    hold_key(4'd9, 1'b0, 6);
    hold_key(4'd9, 1'b1, 70);
    send_item(kdre_pkg::OP_PAUSE, 4'd9, 1'b0);
    hold_key(4'd9, 1'b1, 80);
    hold_key(4'd9, 1'b0, 6);
    hold_key(4'd9, 1'b1, 30);
    send_item(kdre_pkg::OP_KILL, 4'd9, 1'b1);
    hold_key(4'd9, 1'b1, 10);
    hold_key(4'd9, 1'b0, 6);
  endtask

  // Unstructured items over all operation codes and keys.
  task automatic test_noise(int n);
    repeat (n) begin
      send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // Draws the next stretch length for a key whose level just flipped.
  function automatic int draw_stretch(logic level);
    int r;
    r = int'($urandom_range(0, 19));
    if (level) begin
      if (r < 8) return int'($urandom_range(5, 30));
      if (r < 14) return int'($urandom_range(40, 100));
      if (r < 19) return int'($urandom_range(100, 240));
      return int'($urandom_range(240, 320));
    end
    if (r < 4) return int'($urandom_range(1, 3));
    if (r < 14) return int'($urandom_range(4, 20));
    if (r < 19) return int'($urandom_range(21, 60));
    return int'($urandom_range(250, 270));
  endfunction

  // Scan over a group of keys, each following its own press/release plan.
  task automatic test_key_scan(int first_key, int span, int n, bit drains);
    int        k;
    int        r;
    logic [1:0] op;
    for (int i = 0; i < KEY_COUNT; i++) begin
      plan_level[i] = 1'b0;
      plan_left[i]  = 0;
    end
    repeat (n) begin
      k = first_key + int'($urandom_range(0, span - 1));
      if (plan_left[k] == 0) begin
        plan_level[k] = ~plan_level[k];
        plan_left[k]  = draw_stretch(plan_level[k]);
      end
      r = int'($urandom_range(0, 99));
      if (r < 2) op = kdre_pkg::OP_PAUSE;
      else if (r < 4) op = kdre_pkg::OP_KILL;
      else if (r < 5) op = OP_RESERVED;
      else op = kdre_pkg::OP_TICK;
      if (op == kdre_pkg::OP_TICK) begin
        plan_left[k]--;
      end
      send_item(op, 4'(k), plan_level[k]);
      if (drains && $urandom_range(0, 99) == 0) begin
        wait_for_drain();
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = kdre_pkg::OP_TICK;
    key_index_i  = '0;
    raw_sample_i = 1'b0;
    errors       = 0;
    cycles       = 0;
    send_gap_max = 7;
    recv_gap_max = 7;
    for (int i = 0; i < KEY_COUNT; i++) begin
      hist_q[i]    = '0;
      ticks_q[i]   = '0;
      presses_q[i] = '0;
      mode_q[i]    = kdre_pkg::MODE_OFF;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_ticks();
    test_press_release();
    test_commands();
    wait_for_drain();

    send_gap_max = 0;
    recv_gap_max = 7;
    test_long_hold();
    wait_for_drain();

    send_gap_max = 7;
    recv_gap_max = 7;
    test_noise(200);
    wait_for_drain();

    send_gap_max = 0;
    recv_gap_max = 0;
    test_key_scan(0, 2, 500, 1'b0);

    send_gap_max = 7;
    recv_gap_max = 7;
    test_key_scan(int'($urandom_range(0, 12)), 4, 350, 1'b1);

    send_gap_max = 3;
    recv_gap_max = 0;
    test_key_scan(0, 16, 300, 1'b1);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
